>>> src/cff_pkg.sv
package cff_pkg;

  // Stack sizing
  localparam int STACK_DEPTH = 24;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CORNERS     = 8;

  typedef logic [2:0] corner_t;

  // Input and result transactions
  typedef struct packed {
    corner_t     start_corner;
    logic [7:0]  corner_mask;
  } in_item_t;

  typedef struct packed {
    corner_t corner_out;
    logic    last;
  } out_item_t;

  // Walker to stack commands
  typedef struct packed {
    logic    load;
    logic    push;
    logic    pop;
    corner_t corner;
  } stk_cmd_t;

  // Stack status back to the walker
  typedef struct packed {
    logic    empty;
    corner_t top;
  } stk_stat_t;

  // Walker events to the result buffer
  typedef struct packed {
    logic    found;
    logic    done;
    corner_t corner;
  } walk_evt_t;

  // Neighbours of each corner, three octal digits, first neighbour in the top digit
  localparam logic [8:0] NB_TAB [CORNERS] = '{
    9'o134, 9'o025, 9'o136, 9'o027, 9'o057, 9'o146, 9'o257, 9'o346
  };

  function automatic corner_t nb_lookup(corner_t c, logic [1:0] k);
    logic [8:0] row;
    corner_t    nb;
    row = NB_TAB[c];
    case (k)
      2'd0:    nb = row[8:6];
      2'd1:    nb = row[5:3];
      default: nb = row[2:0];
    endcase
    return nb;
  endfunction

endpackage

>>> src/cube_corner_flood_fill.sv
// Cube corner flood fill.
// Input channel: in_valid / in_stall / in_data carries a start corner and an
// 8-bit corner mask. Result channel: out_valid / out_stall / out_data carries
// the connected same-valued corners one per transaction, in depth-first order,
// with last set on the final corner of the set.
// A transaction is taken on a clock edge with valid high and stall low.
// The block handles one input at a time: in_stall stays high from the accepted
// input until its final result has been taken.
// Walk: a load step, then one stack pop step for each entry plus one that sees
// the empty stack, and 3 neighbour checks for each corner found, one check per
// cycle on the shared check unit.
// Results then leave at one per cycle from the result buffer while out_stall
// is low; in_stall drops the cycle after the last one.
// When out_stall is high the current result is held unchanged.
// Reset (rst_n low, synchronous) empties the stack, clears the walk and drops
// any results not yet delivered.
module cube_corner_flood_fill
  import cff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_WALK = 3'b010,
    T_SEND = 3'b100
  } tstate_t;

  tstate_t    state_r, state_nxt;
  logic [3:0] wr_cnt_r, wr_cnt_nxt;
  logic [2:0] rd_r, rd_nxt;
  corner_t    res [CORNERS];

  walk_evt_t  evt;
  logic       start;
  logic       is_last;

  assign in_stall  = (state_r != T_IDLE);
  assign start     = in_valid && !in_stall;
  assign out_valid = (state_r == T_SEND);
  assign is_last   = (({1'b0, rd_r} + 4'd1) == wr_cnt_r);

  assign out_data.corner_out = res[rd_r];
  assign out_data.last       = is_last;

  cff_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .item  (in_data),
    .evt   (evt)
  );

  // Collect then stream
  always_comb begin
    state_nxt  = state_r;
    wr_cnt_nxt = wr_cnt_r;
    rd_nxt     = rd_r;
    unique case (state_r)
      T_IDLE: begin
        if (start) begin
          wr_cnt_nxt = '0;
          state_nxt  = T_WALK;
        end
      end
      T_WALK: begin
        if (evt.found) begin
          wr_cnt_nxt = wr_cnt_r + 1'b1;
        end
        if (evt.done) begin
          rd_nxt    = '0;
          state_nxt = T_SEND;
        end
      end
      T_SEND: begin
        if (!out_stall) begin
          if (is_last) begin
            state_nxt = T_IDLE;
          end else begin
            rd_nxt = rd_r + 1'b1;
          end
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_IDLE;
      wr_cnt_r <= '0;
      rd_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      wr_cnt_r <= wr_cnt_nxt;
      rd_r     <= rd_nxt;
    end
  end

  // Result buffer, at most one entry per corner
  always_ff @(posedge clk) begin
    if ((state_r == T_WALK) && evt.found) begin
      res[wr_cnt_r[2:0]] <= evt.corner;
    end
  end

endmodule

>>> src/cff_stack.sv
module cff_stack
  import cff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat
);

  corner_t          mem [STACK_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] count_dec;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             not_full;

  assign count_dec = count_r - 1'b1;
  assign top_idx   = count_dec[IDX_W-1:0];
  assign wr_idx    = count_r[IDX_W-1:0];
  assign not_full  = (count_r < CNT_W'(STACK_DEPTH));

  assign stat.empty = (count_r == '0);
  assign stat.top   = mem[top_idx];

  // Fill level; a push onto a full stack is dropped
  always_comb begin
    count_nxt = count_r;
    if (cmd.load) begin
      count_nxt = CNT_W'(1);
    end else if (cmd.push && not_full) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop && !stat.empty) begin
      count_nxt = count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[0] <= cmd.corner;
    end else if (cmd.push && not_full) begin
      mem[wr_idx] <= cmd.corner;
    end
  end

endmodule

>>> src/cff_walk.sv
module cff_walk
  import cff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  item,
  output walk_evt_t evt
);

  typedef enum logic [2:0] {
    W_IDLE  = 3'b001,
    W_POP   = 3'b010,
    W_CHECK = 3'b100
  } wstate_t;

  wstate_t    state_r, state_nxt;
  logic [7:0] visited_r, visited_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic       sv_r, sv_nxt;
  corner_t    cur_r, cur_nxt;
  logic [1:0] k_r, k_nxt;

  stk_cmd_t   cmd;
  stk_stat_t  stat;
  corner_t    nb;

  cff_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Shared neighbour check, one neighbour per cycle
  assign nb = nb_lookup(cur_r, k_r);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    visited_nxt = visited_r;
    mask_nxt    = mask_r;
    sv_nxt      = sv_r;
    cur_nxt     = cur_r;
    k_nxt       = k_r;
    cmd         = '0;
    evt         = '0;
    unique case (state_r)
      W_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.corner  = item.start_corner;
          mask_nxt    = item.corner_mask;
          sv_nxt      = item.corner_mask[item.start_corner];
          visited_nxt = '0;
          state_nxt   = W_POP;
        end
      end
      W_POP: begin
        if (stat.empty) begin
          evt.done  = 1'b1;
          state_nxt = W_IDLE;
        end else begin
          cmd.pop = 1'b1;
          // already visited corners are dropped here
          if (!visited_r[stat.top]) begin
            visited_nxt = visited_r | (8'b1 << stat.top);
            evt.found   = 1'b1;
            evt.corner  = stat.top;
            cur_nxt     = stat.top;
            k_nxt       = '0;
            state_nxt   = W_CHECK;
          end
        end
      end
      W_CHECK: begin
        if (!visited_r[nb] && (mask_r[nb] == sv_r)) begin
          cmd.push   = 1'b1;
          cmd.corner = nb;
        end
        if (k_r == 2'd2) begin
          state_nxt = W_POP;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= W_IDLE;
      visited_r <= '0;
      sv_r      <= 1'b0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      visited_r <= visited_nxt;
      sv_r      <= sv_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    cur_r  <= cur_nxt;
  end

endmodule

>>> tb/sv/cff_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the flood fill block, predicts the corner walk for
// every accepted input transaction and checks each result transaction in order.
module cff_checker
  import cff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        pending,
  output int        mismatches
);

  // Cube edges, three neighbours per corner in walk order
  localparam corner_t CUBE_ADJ [CORNERS][3] = '{
    '{3'd1, 3'd3, 3'd4}, '{3'd0, 3'd2, 3'd5}, '{3'd1, 3'd3, 3'd6}, '{3'd0, 3'd2, 3'd7},
    '{3'd0, 3'd5, 3'd7}, '{3'd1, 3'd4, 3'd6}, '{3'd2, 3'd5, 3'd7}, '{3'd3, 3'd4, 3'd6}
  };

  out_item_t expected_corners [$];
  int        fail_total = 0;

  task automatic report_mismatch(input string what);
    fail_total++;
    $display("%0d ns: MISMATCH %s", $time, what);
  endtask

  // Depth-first walk over same-valued corners, appending the expected results
  function automatic void flood_walk(input in_item_t item);
    corner_t    stack [STACK_DEPTH];
    int         depth;
    logic [7:0] seen;
    logic       start_bit;
    corner_t    c;
    corner_t    nb;
    out_item_t  res;
    seen      = '0;
    start_bit = item.corner_mask[item.start_corner];
    stack[0]  = item.start_corner;
    depth     = 1;
    while (depth > 0) begin
      depth--;
      c = stack[depth];
      // a corner pushed twice is dropped on its second pop
      if (!seen[c]) begin
        seen[c]        = 1'b1;
        res.corner_out = c;
        res.last       = 1'b0;
        expected_corners.push_back(res);
        for (int k = 0; k < 3; k++) begin
          nb = CUBE_ADJ[c][k];
          if (!seen[nb] && item.corner_mask[nb] == start_bit && depth < STACK_DEPTH) begin
            stack[depth] = nb;
            depth++;
          end
        end
      end
    end
    // final corner of the set carries the last flag
    res      = expected_corners.pop_back();
    res.last = 1'b1;
    expected_corners.push_back(res);
  endfunction

  // Sample both channels at each edge
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_corners.size() == 0) begin
          report_mismatch($sformatf("unexpected result corner %0d last %0b",
                                    out_data.corner_out, out_data.last));
        end else begin
          exp_item = expected_corners.pop_front();
          if (out_data.corner_out !== exp_item.corner_out)
            report_mismatch($sformatf("corner_out got %0d expected %0d",
                                      out_data.corner_out, exp_item.corner_out));
          if (out_data.last !== exp_item.last)
            report_mismatch($sformatf("last got %0b expected %0b on corner %0d",
                                      out_data.last, exp_item.last, exp_item.corner_out));
        end
      end
      if (in_valid && !in_stall)
        flood_walk(in_data);
    end
    pending    <= expected_corners.size();
    mismatches <= fail_total;
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import cff_pkg::*;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        pending;
  int        mismatches;
  // no idling on either side while set
  logic      quiet     = 1'b0;

  cube_corner_flood_fill i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  cff_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #2_000_000;
    $display("cube_corner_flood_fill test failed");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 20);
  end

  // One input transaction, with random idle cycles ahead of it
  task automatic send_walk(input corner_t start, input logic [7:0] mask);
    in_item_t item;
    item.start_corner = start;
    item.corner_mask  = mask;
    while (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off the sender until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] mask;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: whole cube alike from every corner (repeated stack entries)
    for (int c = 0; c < CORNERS; c++) send_walk(corner_t'(c), 8'hFF);
    for (int c = 0; c < CORNERS; c++) send_walk(corner_t'(c), 8'h00);
    // isolated start corners, checkerboard masks isolate every corner
    send_walk(3'd0, 8'h01);
    send_walk(3'd7, 8'h7F);
    send_walk(3'd3, 8'hA5);
    send_walk(3'd4, 8'h5A);
    // half cubes and odd shapes
    send_walk(3'd2, 8'h0F);
    send_walk(3'd6, 8'h3C);
    send_walk(3'd5, 8'hC3);
    wait_drained();

    // Random walks, mask density varied to spread the set sizes
    for (int n = 0; n < 360; n++) begin
      quiet = (n >= 120 && n < 220);
      if (n == 60) wait_drained();
      mask = 8'($urandom_range(255));
      case ($urandom_range(3))
        0:       mask = mask & 8'($urandom_range(255));
        1:       mask = mask | 8'($urandom_range(255));
        default: ;
      endcase
      send_walk(corner_t'($urandom_range(7)), mask);
    end
    quiet = 1'b0;

    // Drain and allow for a late stray result
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("cube_corner_flood_fill test passed");
    end else begin
      $display("cube_corner_flood_fill test failed");
    end
    $finish;
  end

endmodule
